### src/abts_pkg.sv
// Shared types and constants for the implicit-array tree sorter.
// No dependencies; every other source file but abts_tree_ram imports this package.
package abts_pkg;

   localparam int TREE_DEPTH = 10;
   localparam int KEY_WIDTH  = 16;
   localparam int VALUE_W    = 16;
   localparam int STATUS_W   = 3;

   // Stored key width: the value field bounds it from above.
   localparam int KEY_W      = (KEY_WIDTH < VALUE_W) ? KEY_WIDTH : VALUE_W;
   localparam int TREE_SLOTS = (1 << TREE_DEPTH) - 1;
   localparam int NODE_W     = TREE_DEPTH;
   localparam int SP_W       = $clog2(TREE_DEPTH + 1);
   localparam int STK_W      = $clog2(TREE_DEPTH);

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [SP_W-1:0]   sp_type;

   // All-ones index lies past the last slot: marks "no node".
   localparam node_type NODE_NONE = node_type'(TREE_SLOTS);
   localparam node_type NODE_ROOT = '0;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_READ   = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED   = 3'd0,
      ST_DUP      = 3'd1,
      ST_ZERO     = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_READ     = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_INS,
      S_ROOT,
      S_DESC,
      S_CHECK,
      S_TOP,
      S_RIGHT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic     wr_en;
      node_type wr_addr;
      key_type  wr_data;
      node_type rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                valid;
      logic [VALUE_W-1:0]  out_value;
      status_type          status;
      logic                last;
   } result_type;

endpackage

### src/abts_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on abts_pkg for field widths.
interface abts_req_if import abts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

### src/abts_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on abts_pkg for field widths and the status type.
interface abts_rsp_if import abts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] out_value;
   status_type         status;
   logic               last;

   modport source (output valid, output out_value, output status, output last, input ready);
   modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

### src/abts_tree_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
// Standalone; holds the tree slots.
module abts_tree_ram #(
   parameter int DEPTH  = 1023,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/abts_ctrl.sv
// Sequencer for insert walks, in-order read walks and the clearing sweep.
// Depends on abts_pkg and abts_req_if; drives the tree RAM.
module abts_ctrl import abts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   abts_req_if.sink     req_chan,
   output mem_req_type  mem_req,
   input  key_type      mem_rdata,
   output result_type   result,
   input  logic         result_taken
);

   localparam logic [NODE_W:0] SLOTS_X = (NODE_W+1)'(TREE_SLOTS);
   localparam logic [NODE_W:0] STEP_L  = (NODE_W+1)'(1);
   localparam logic [NODE_W:0] STEP_R  = (NODE_W+1)'(2);

   state_type  state_ff, state_in;
   node_type   clr_ff, clr_in;
   node_type   ins_node_ff, ins_node_in;
   node_type   node_ff, node_in;      // in-order walk position
   sp_type     sp_ff, sp_in;
   logic       active_ff, active_in;
   node_type   top_ff, top_in;
   logic       right_ok_ff, right_ok_in;
   key_type    key_ff, key_in;
   key_type    val_ff, val_in;
   status_type status_ff, status_in;
   logic       last_ff, last_in;

   node_type   stack_ff [TREE_DEPTH];
   logic       push_en;

   sp_type          sp_dec;
   logic [NODE_W:0] ins_child;
   logic [NODE_W:0] left_child;
   logic [NODE_W:0] right_child;
   node_type        left_clamp;
   node_type        walk_start;

   assign sp_dec      = sp_ff - sp_type'(1);
   assign ins_child   = {ins_node_ff, 1'b0} + ((key_ff > mem_rdata) ? STEP_R : STEP_L);
   assign left_child  = {node_ff, 1'b0} + STEP_L;
   assign right_child = {top_ff, 1'b0} + STEP_R;
   assign left_clamp  = (left_child >= SLOTS_X) ? NODE_NONE : left_child[NODE_W-1:0];
   assign walk_start  = active_ff ? node_ff : NODE_ROOT;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         node_ff   <= NODE_ROOT;
         sp_ff     <= '0;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         node_ff   <= node_in;
         sp_ff     <= sp_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_node_ff <= ins_node_in;
      top_ff      <= top_in;
      right_ok_ff <= right_ok_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
      if (push_en) begin
         stack_ff[sp_ff[STK_W-1:0]] <= node_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      ins_node_in = ins_node_ff;
      node_in     = node_ff;
      sp_in       = sp_ff;
      active_in   = active_ff;
      top_in      = top_ff;
      right_ok_in = right_ok_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      status_in   = status_ff;
      last_in     = last_ff;
      push_en     = 1'b0;
      mem_req     = '0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            clr_in          = clr_ff + node_type'(1);
            if (clr_ff == node_type'(TREE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               key_in  = req_chan.value[KEY_W-1:0];
               val_in  = '0;
               last_in = 1'b0;
               mem_req.rd_addr = NODE_ROOT;
               if (req_chan.req_type == REQ_INSERT) begin
                  ins_node_in = NODE_ROOT;
                  if (req_chan.value[KEY_W-1:0] == '0) begin
                     status_in = ST_ZERO;
                     state_in  = S_RESP;
                  end else begin
                     state_in  = S_INS;
                  end
               end else begin
                  state_in = S_ROOT;
               end
            end
         end

         // One level per cycle; the write ends the walk, so no read follows it here.
         S_INS: begin
            priority if (mem_rdata == '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ins_node_ff;
               mem_req.wr_data = key_ff;
               status_in       = ST_STORED;
               state_in        = S_RESP;
            end else if (key_ff == mem_rdata) begin
               status_in = ST_DUP;
               state_in  = S_RESP;
            end else if (ins_child >= SLOTS_X) begin
               status_in = ST_OVERFLOW;
               state_in  = S_RESP;
            end else begin
               ins_node_in     = ins_child[NODE_W-1:0];
               mem_req.rd_addr = ins_child[NODE_W-1:0];
            end
         end

         S_ROOT: begin
            if (mem_rdata == '0) begin
               status_in = ST_EMPTY;
               active_in = 1'b0;
               sp_in     = '0;
               node_in   = NODE_ROOT;
               state_in  = S_RESP;
            end else begin
               if (!active_ff) begin
                  active_in = 1'b1;
                  sp_in     = '0;
               end
               node_in = walk_start;
               if (walk_start == NODE_NONE) begin
                  state_in = S_CHECK;
               end else begin
                  mem_req.rd_addr = walk_start;
                  state_in        = S_DESC;
               end
            end
         end

         // Push while the slot is full, stepping to the left child.
         S_DESC: begin
            if (mem_rdata != '0 && sp_ff < sp_type'(TREE_DEPTH)) begin
               push_en = 1'b1;
               sp_in   = sp_ff + sp_type'(1);
               node_in = left_clamp;
               if (left_clamp == NODE_NONE || sp_ff == sp_type'(TREE_DEPTH - 1)) begin
                  state_in = S_CHECK;
               end else begin
                  mem_req.rd_addr = left_clamp;
               end
            end else begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            if (sp_ff == '0) begin
               // inconsistent walk: restart from the root
               node_in         = NODE_ROOT;
               mem_req.rd_addr = NODE_ROOT;
               state_in        = S_DESC;
            end else begin
               sp_in           = sp_dec;
               top_in          = stack_ff[sp_dec[STK_W-1:0]];
               mem_req.rd_addr = stack_ff[sp_dec[STK_W-1:0]];
               state_in        = S_TOP;
            end
         end

         S_TOP: begin
            val_in = mem_rdata;
            if (right_child < SLOTS_X) begin
               right_ok_in     = 1'b1;
               node_in         = right_child[NODE_W-1:0];
               mem_req.rd_addr = right_child[NODE_W-1:0];
            end else begin
               right_ok_in = 1'b0;
               node_in     = NODE_NONE;
            end
            state_in = S_RIGHT;
         end

         S_RIGHT: begin
            status_in = ST_READ;
            if (sp_ff == '0 && !(right_ok_ff && mem_rdata != '0)) begin
               last_in   = 1'b1;
               active_in = 1'b0;
               node_in   = NODE_ROOT;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (result_taken) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result.valid     = (state_ff == S_RESP);
   assign result.out_value = VALUE_W'(val_ff);
   assign result.status    = status_ff;
   assign result.last      = last_ff;

endmodule

### src/array_bst_tree_sorter.sv
// Tree sorter: binary search tree in an implicit array, in-order readout.
// Insert walk: one RAM read per level of the tree. read_next: descent one level
// per read, then pop, key and right child.
// Throughput: one word in flight; the next is taken once the result is in the output reg.
// Reset: synchronous; a clearing sweep writes all TREE_SLOTS (1023) slots, one per
// cycle, and no request word is accepted until it finishes.
module array_bst_tree_sorter import abts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   abts_req_if.sink   req_chan,
   abts_rsp_if.source rsp_chan
);

   mem_req_type mem_req;
   key_type     mem_rdata;
   result_type  result;
   logic        out_free;

   // Output register state
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   status_type         rsp_status_ff;
   logic               rsp_last_ff;

   // Tree slots; key 0 means empty.
   abts_tree_ram #(
      .DEPTH (TREE_SLOTS),
      .WIDTH (KEY_W)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata)
   );

   // Walk sequencer and in-order stack.
   abts_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .mem_req      (mem_req),
      .mem_rdata    (mem_rdata),
      .result       (result),
      .result_taken (out_free)
   );

   // Output slot can take a new word when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid && out_free) begin
         rsp_value_ff  <= result.out_value;
         rsp_status_ff <= result.status;
         rsp_last_ff   <= result.last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_value = rsp_value_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

### tb/sv/array_bst_tree_sorter_tb.sv
`timescale 1ns / 100ps
// Testbench for array_bst_tree_sorter: random and directed insert/read words,
// with its own tree predictor in a scoreboard class. Depends on abts_pkg and the
// abts_req_if / abts_rsp_if interfaces from the RTL sources.
module array_bst_tree_sorter_tb import abts_pkg::*; ();

   // ---------------------------------------------------------------------
   // Run parameters
   // ---------------------------------------------------------------------
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_WORDS = 550;
   localparam int IDLE_PCT     = 27;    // chance per cycle that a side idles
   localparam int QUIET_FROM   = 250;   // no idling on either side in this window
   localparam int QUIET_TO     = 350;
   localparam int HOLD_AT      = 150;   // result count at which the long hold-off starts
   localparam int HOLD_LEN     = 300;   // cycles the receiver keeps ready low
   localparam int DRAIN_CYCLES = 40;    // longer than the worst read walk
   // STALL_LIMIT lies above both the clearing sweep after reset and the hold-off.
   localparam int STALL_LIMIT  = 5000;

   // One expected result word
   typedef struct {
      logic [VALUE_W-1:0] value;
      status_type         status;
      logic               last;
   } sorted_word_type;

   // ---------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the tree and the in-order walk,
   // predicts every result at the time the request word is accepted.
   // ---------------------------------------------------------------------
   class sorter_tracker;
      key_type         slots[TREE_SLOTS];
      int unsigned     walk_stack[TREE_DEPTH];
      int unsigned     depth_ptr;
      int unsigned     walk_node;
      bit              walk_on;
      sorted_word_type pending[$];
      int unsigned     mismatches;

      function new();
         foreach (slots[i]) slots[i] = '0;
         foreach (walk_stack[i]) walk_stack[i] = 0;
         depth_ptr  = 0;
         walk_node  = 0;
         walk_on    = 1'b0;
         mismatches = 0;
      endfunction

      function bit occupied(int unsigned idx);
         if (idx >= TREE_SLOTS) return 1'b0;
         return slots[idx] != '0;
      endfunction

      // Walk down from the root and drop the key into the first empty slot.
      function status_type insert_key(key_type key);
         int unsigned node;
         int unsigned nxt;
         node = 0;
         if (key == '0) return ST_ZERO;
         for (int lvl = 0; lvl < TREE_DEPTH; lvl++) begin
            if (slots[node] == '0) begin
               slots[node] = key;
               return ST_STORED;
            end
            if (key == slots[node]) return ST_DUP;
            nxt = 2 * node + ((key > slots[node]) ? 2 : 1);
            if (nxt >= TREE_SLOTS) return ST_OVERFLOW;
            node = nxt;
         end
         return ST_OVERFLOW;
      endfunction

      // Push the left spine below walk_node onto the walk stack.
      function void push_left();
         while (occupied(walk_node) && depth_ptr < TREE_DEPTH) begin
            walk_stack[depth_ptr] = walk_node;
            depth_ptr++;
            walk_node = 2 * walk_node + 1;
         end
      endfunction

      // Next key in ascending order; restarts after the greatest one.
      function sorted_word_type read_next();
         sorted_word_type r;
         int unsigned     top;
         int unsigned     right;
         r.value  = '0;
         r.last   = 1'b0;
         r.status = ST_READ;
         if (slots[0] == '0) begin
            r.status  = ST_EMPTY;
            walk_on   = 1'b0;
            depth_ptr = 0;
            walk_node = 0;
            return r;
         end
         if (!walk_on) begin
            walk_on   = 1'b1;
            depth_ptr = 0;
            walk_node = 0;
         end
         push_left();
         if (depth_ptr == 0) begin
            walk_node = 0;
            push_left();
         end
         depth_ptr--;
         top = walk_stack[depth_ptr];
         if (top >= TREE_SLOTS) top = 0;
         r.value   = VALUE_W'(slots[top]);
         right     = 2 * top + 2;
         walk_node = (right < TREE_SLOTS) ? right : TREE_SLOTS;
         if (depth_ptr == 0 && !occupied(right)) begin
            r.last    = 1'b1;
            walk_on   = 1'b0;
            walk_node = 0;
         end
         return r;
      endfunction

      function void note_request(req_kind_type kind, logic [VALUE_W-1:0] value);
         sorted_word_type r;
         if (kind == REQ_INSERT) begin
            r.value  = '0;
            r.status = insert_key(key_type'(value));
            r.last   = 1'b0;
         end else begin
            r = read_next();
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [VALUE_W-1:0] value, status_type status, logic last);
         sorted_word_type e;
         if (pending.size() == 0) begin
            $error("unexpected result word: out_value %0d status %0d last %0b",
                   value, status, last);
            mismatches++;
            return;
         end
         e = pending.pop_front();
         if (value !== e.value) begin
            $error("out_value: expected %0d, actual %0d", e.value, value);
            mismatches++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            mismatches++;
         end
         if (last !== e.last) begin
            $error("last: expected %0b, actual %0b", e.last, last);
            mismatches++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   abts_req_if req_chan ();
   abts_rsp_if rsp_chan ();

   array_bst_tree_sorter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sorter_tracker      tracker = new();
   int unsigned        words_sent   = 0;
   int unsigned        results_seen = 0;
   int unsigned        stall_cycles = 0;
   logic [VALUE_W-1:0] run_key      = 16'd1000;

   function automatic bit quiet_window(int unsigned count);
      return count >= QUIET_FROM && count < QUIET_TO;
   endfunction

   // Key mix: zeros, a narrow window (duplicates, small tree), ascending
   // runs (deep right spines, depth overflow), and full-range keys.
   function automatic logic [VALUE_W-1:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return '0;
      if (roll < 63) return VALUE_W'($urandom_range(40, 1));
      if (roll < 75) begin
         if ($urandom_range(9) == 0) run_key = VALUE_W'($urandom_range(65000, 41));
         run_key = run_key + 1'b1;
         return run_key;
      end
      return VALUE_W'($urandom);
   endfunction

   // Offer one request word and hold it until the block takes it.
   // valid stays high across back-to-back words; it only drops on idle cycles.
   task automatic send_word(input req_kind_type kind, input logic [VALUE_W-1:0] value);
      if (!quiet_window(words_sent)) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.value    <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      tracker.note_request(kind, value);
      words_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int unsigned n;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= REQ_INSERT;
      req_chan.value    <= '0;
      reset             <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: read from an empty tree, refused zero, largest key at the
      // root, then a chain 1..10 down the left/right spine; key 10 runs past
      // the last level and is dropped. Duplicate, then a full in-order pass
      // with the walk wrapping back to the smallest key.
      send_word(REQ_READ, 16'hFFFF);
      send_word(REQ_INSERT, '0);
      send_word(REQ_INSERT, 16'hFFFF);
      for (n = 1; n <= 10; n++) send_word(REQ_INSERT, VALUE_W'(n));
      send_word(REQ_INSERT, 16'd5);
      for (n = 0; n < 11; n++) send_word(REQ_READ, '0);

      // Random: rounds of insert bursts then read bursts with a few inserts
      // mixed in, so walks are cut by inserts and also run through to last.
      n = 0;
      while (n < RANDOM_WORDS) begin
         repeat ($urandom_range(20, 3)) begin
            send_word(REQ_INSERT, pick_key());
            n++;
         end
         repeat ($urandom_range(45, 5)) begin
            if ($urandom_range(99) < 15) send_word(REQ_INSERT, pick_key());
            else send_word(REQ_READ, VALUE_W'($urandom));
            n++;
         end
      end

      req_chan.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random back-pressure, one long hold-off so the block fills
   // and stalls its input, and a stretch with ready held high.
   // ---------------------------------------------------------------------
   initial begin
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            tracker.check_result(rsp_chan.out_value, rsp_chan.status, rsp_chan.last);
            results_seen++;
         end
         if (results_seen == HOLD_AT && !hold_done) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (quiet_window(results_seen)) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
